### rtl/feedback_limit_watchdog_unit_defines.svh
// Assertion macros shared by the watchdog RTL.
// No dependencies; defining ASSERT_OFF compiles the checks out.
`ifndef FEEDBACK_LIMIT_WATCHDOG_UNIT_DEFINES_SVH
`define FEEDBACK_LIMIT_WATCHDOG_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define FWL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fwl assertion failed");
`define FWL_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fwl reset assertion failed");
`else
`define FWL_ASSERT(lbl, clk, rst_n, prop)
`define FWL_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

### rtl/fwl_pkg.sv
// Shared types and constants of the feedback limit watchdog.
// No dependencies; imported by fwl_eval, fwl_totals and the top level.
package fwl_pkg;

  localparam int CH_W       = 8;
  localparam int SAMPLE_W   = 32;
  localparam int LIMIT_W    = 31;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 32;
  localparam int CMP_W      = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int KIND_W     = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    REQ_BEAM_UM = 3'd0,
    REQ_BEAM_NM = 3'd1,
    REQ_SLOW    = 3'd2,
    REQ_FAST    = 3'd3,
    REQ_LOAD    = 3'd4
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_LIMIT_MICRO = 3'd0,
    CFG_BEAM_LIMIT_NANO  = 3'd1,
    CFG_BEAM_TRIP_COUNT  = 3'd2,
    CFG_SLOW_TRIP_COUNT  = 3'd3,
    CFG_FAST_TRIP_COUNT  = 3'd4,
    CFG_SLOW_MIN_MARGIN  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] beam_limit_micro;
    logic [LIMIT_W-1:0] beam_limit_nano;
    logic [LIMIT_W-1:0] slow_min_margin;
    logic [CNT_W-1:0]   beam_trip_count;
    logic [CNT_W-1:0]   slow_trip_count;
    logic [CNT_W-1:0]   fast_trip_count;
  } cfg_t;

  typedef struct packed {
    logic trip;
    logic beam_inc;
    logic slow_inc;
    logic fast_inc;
  } trip_info_t;

endpackage

### rtl/fwl_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds per-channel state of the watchdog.
module fwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fwl_eval.sv
// Trip evaluation and row update for one transaction of the watchdog.
// Depends on fwl_pkg; feeds the state write-back and the totals stage.
module fwl_eval #(
  parameter int SW    = 32,
  parameter int ROW_W = 3 * fwl_pkg::CNT_W + SW
) (
  input  logic [fwl_pkg::KIND_W-1:0] kind,
  input  logic                       in_range,
  input  logic signed [SW-1:0]       x,
  input  logic [ROW_W-1:0]           row,
  input  logic signed [SW-1:0]       hard_limit,
  input  fwl_pkg::cfg_t              cfg,
  output logic [ROW_W-1:0]           row_new,
  output logic                       row_wr,
  output logic                       hl_wr,
  output fwl_pkg::trip_info_t        info
);
  import fwl_pkg::*;

  localparam int BEAM_LSB = SW;
  localparam int SLOW_LSB = SW + CNT_W;
  localparam int FAST_LSB = SW + 2 * CNT_W;

  req_kind_t               k;
  logic signed [CMP_W-1:0] x_e, h_e, sv_e, lim_e, m_e;
  logic signed [CMP_W-1:0] b_sum, s_up, s_lo, f_sum, f_up, f_lo;
  logic                    beam_hit, slow_hit, fast_hit;
  logic [CNT_W-1:0]        beam_nxt, slow_nxt, fast_nxt;
  logic [SW-1:0]           sv;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign k     = req_kind_t'(kind);
  assign sv    = row[SW-1:0];
  assign x_e   = {{(CMP_W-SW){x[SW-1]}}, x};
  assign h_e   = {{(CMP_W-SW){hard_limit[SW-1]}}, hard_limit};
  assign sv_e  = {{(CMP_W-SW){sv[SW-1]}}, sv};
  assign m_e   = {{(CMP_W-LIMIT_W){1'b0}}, cfg.slow_min_margin};
  assign lim_e = {{(CMP_W-LIMIT_W){1'b0}},
                  (k == REQ_BEAM_NM) ? cfg.beam_limit_nano : cfg.beam_limit_micro};

  // |x| >= lim  <=>  x >= lim or x + lim <= 0
  assign b_sum    = x_e + lim_e;
  assign beam_hit = (x_e >= lim_e) || b_sum[CMP_W-1] || (b_sum == '0);

  // h <= 0, h - x < m, or h + x < m
  assign s_up     = h_e - x_e - m_e;
  assign s_lo     = h_e + x_e - m_e;
  assign slow_hit = h_e[CMP_W-1] || (h_e == '0) || s_up[CMP_W-1] || s_lo[CMP_W-1];

  // |s + x| >= h  <=>  s + x - h >= 0 or s + x + h <= 0
  assign f_sum    = sv_e + x_e;
  assign f_up     = f_sum - h_e;
  assign f_lo     = f_sum + h_e;
  assign fast_hit = !f_up[CMP_W-1] || f_lo[CMP_W-1] || (f_lo == '0);

  assign beam_nxt = sat_inc(row[BEAM_LSB +: CNT_W]);
  assign slow_nxt = sat_inc(row[SLOW_LSB +: CNT_W]);
  assign fast_nxt = sat_inc(row[FAST_LSB +: CNT_W]);

  always_comb begin
    row_new = row;
    row_wr  = 1'b0;
    hl_wr   = 1'b0;
    info    = '0;
    unique case (k)
      REQ_BEAM_UM, REQ_BEAM_NM: begin
        row_wr = in_range;
        if (beam_hit) begin
          row_new[BEAM_LSB +: CNT_W] = beam_nxt;
          info.trip     = in_range;
          info.beam_inc = in_range && (beam_nxt >= cfg.beam_trip_count);
        end
      end
      REQ_SLOW: begin
        row_wr          = in_range;
        row_new[SW-1:0] = x;
        if (slow_hit) begin
          row_new[SLOW_LSB +: CNT_W] = slow_nxt;
          info.trip     = in_range;
          info.slow_inc = in_range && (slow_nxt >= cfg.slow_trip_count);
        end
      end
      REQ_FAST: begin
        row_wr = in_range;
        if (fast_hit) begin
          row_new[FAST_LSB +: CNT_W] = fast_nxt;
          info.trip     = in_range;
          info.fast_inc = in_range && (fast_nxt >= cfg.fast_trip_count);
        end
      end
      REQ_LOAD: begin
        hl_wr = in_range;
      end
      default: ;
    endcase
  end

endmodule

### rtl/fwl_totals.sv
// Totals stage and result register of the watchdog.
// Depends on fwl_pkg and the assertion macro header.
`include "feedback_limit_watchdog_unit_defines.svh"
module fwl_totals (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  fwl_pkg::trip_info_t      in_info,
  output logic                     ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_tripped_now,
  output logic                     out_alarm,
  output logic [fwl_pkg::SUM_W-1:0] out_beam_total,
  output logic [fwl_pkg::SUM_W-1:0] out_slow_total,
  output logic [fwl_pkg::SUM_W-1:0] out_fast_total
);
  import fwl_pkg::*;

  logic             s2_v_r;
  trip_info_t       s2_info_r;
  logic             s2_adv;
  logic             out_v_r;
  logic             trip_r;
  logic [SUM_W-1:0] beam_sum_r, slow_sum_r, fast_sum_r;
  logic [SUM_W-1:0] beam_sum_nxt, slow_sum_nxt, fast_sum_nxt;

  assign s2_adv = s2_v_r && (!out_v_r || !out_stall);
  assign ready  = !s2_v_r || s2_adv;

  assign beam_sum_nxt = beam_sum_r + SUM_W'(s2_info_r.beam_inc && (beam_sum_r != SUM_MAX));
  assign slow_sum_nxt = slow_sum_r + SUM_W'(s2_info_r.slow_inc && (slow_sum_r != SUM_MAX));
  assign fast_sum_nxt = fast_sum_r + SUM_W'(s2_info_r.fast_inc && (fast_sum_r != SUM_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      beam_sum_r <= '0;
      slow_sum_r <= '0;
      fast_sum_r <= '0;
    end else begin
      if (ready) begin
        s2_v_r <= in_valid;
      end
      if (!out_v_r || !out_stall) begin
        out_v_r <= s2_v_r;
      end
      if (s2_adv) begin
        beam_sum_r <= beam_sum_nxt;
        slow_sum_r <= slow_sum_nxt;
        fast_sum_r <= fast_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      s2_info_r <= in_info;
    end
    if (s2_adv) begin
      trip_r <= s2_info_r.trip;
    end
  end

  assign out_valid       = out_v_r;
  assign out_tripped_now = trip_r;
  assign out_alarm       = (beam_sum_r != '0) || (slow_sum_r != '0) || (fast_sum_r != '0);
  assign out_beam_total  = beam_sum_r;
  assign out_slow_total  = slow_sum_r;
  assign out_fast_total  = fast_sum_r;

  `FWL_ASSERT(a_sums_monotonic, clk, rst_n,
    $past(rst_n) |-> (beam_sum_r >= $past(beam_sum_r) && slow_sum_r >= $past(slow_sum_r) && fast_sum_r >= $past(fast_sum_r)))
  `FWL_ASSERT(a_stalled_result_holds, clk, rst_n,
    (out_v_r && out_stall) |=> (out_v_r && $stable(beam_sum_r) && $stable(slow_sum_r) && $stable(fast_sum_r)))
  `FWL_ASSERT(a_s2_waits, clk, rst_n, (s2_v_r && !s2_adv) |=> s2_v_r)
  `FWL_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> (!out_v_r && !s2_v_r))

endmodule

### rtl/feedback_limit_watchdog_unit.sv
// Top level of the feedback limit watchdog: config registers, state RAMs,
// forwarding and pipeline control. Depends on fwl_pkg, fwl_ram, fwl_eval,
// fwl_totals and the assertion macro header.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_stall  | in_req_type, in_channel, in_sample_value
//   out     | out_valid/out_stall| out_tripped_now, out_alarm, out_*_total
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction per clock sustained while out_stall stays low; the result follows
// acceptance through registered RAM read, evaluation with row write-back, then the totals stage.
// Same-channel back-to-back updates are covered by a one-deep write forward.
// Reset clears per-row valid flops at once; no clearing pass, hard limits
// are left unset. in_stall rises only when the evaluation stage is full and
// the totals stage cannot take it; the result register holds under out_stall.
`include "feedback_limit_watchdog_unit_defines.svh"
module feedback_limit_watchdog_unit #(
  parameter int CHANNELS   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fwl_pkg::KIND_W-1:0]     in_req_type,
  input  logic [fwl_pkg::CH_W-1:0]       in_channel,
  input  logic signed [fwl_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_tripped_now,
  output logic                           out_alarm,
  output logic [fwl_pkg::SUM_W-1:0]      out_beam_total,
  output logic [fwl_pkg::SUM_W-1:0]      out_slow_total,
  output logic [fwl_pkg::SUM_W-1:0]      out_fast_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fwl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fwl_pkg::*;

  localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
  localparam int ROW_W = 3 * CNT_W + SW;

  cfg_t cfg_r;

  logic                in_acc, in_ok;
  logic [AW-1:0]       in_addr;
  logic signed [SW-1:0] in_x;

  logic                s1_v_r, s1_ok_r, s1_adv;
  logic [KIND_W-1:0]   s1_kind_r;
  logic [AW-1:0]       s1_addr_r;
  logic signed [SW-1:0] s1_x_r;

  logic [DEPTH-1:0]    row_vld_r;
  logic                row_vld_q_r;
  logic [ROW_W-1:0]    row_rd, row_cur, row_new;
  logic [SW-1:0]       hl_rd, hl_cur;
  logic                row_wr_req, hl_wr_req, row_we, hl_we;

  logic                row_fwd_v_r, hl_fwd_v_r;
  logic [AW-1:0]       row_fwd_addr_r, hl_fwd_addr_r;
  logic [ROW_W-1:0]    row_fwd_data_r;
  logic [SW-1:0]       hl_fwd_data_r;

  trip_info_t          info;
  logic                s2_ready;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beam_limit_micro <= '0;
      cfg_r.beam_limit_nano  <= '0;
      cfg_r.slow_min_margin  <= '0;
      cfg_r.beam_trip_count  <= CNT_W'(1);
      cfg_r.slow_trip_count  <= CNT_W'(1);
      cfg_r.fast_trip_count  <= CNT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BEAM_LIMIT_MICRO: cfg_r.beam_limit_micro <= cfg_data[LIMIT_W-1:0];
        CFG_BEAM_LIMIT_NANO:  cfg_r.beam_limit_nano  <= cfg_data[LIMIT_W-1:0];
        CFG_BEAM_TRIP_COUNT:  cfg_r.beam_trip_count  <= cfg_data[CNT_W-1:0];
        CFG_SLOW_TRIP_COUNT:  cfg_r.slow_trip_count  <= cfg_data[CNT_W-1:0];
        CFG_FAST_TRIP_COUNT:  cfg_r.fast_trip_count  <= cfg_data[CNT_W-1:0];
        CFG_SLOW_MIN_MARGIN:  cfg_r.slow_min_margin  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input and evaluation stage
  assign in_stall = s1_v_r && !s2_ready;
  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_v_r && s2_ready;
  assign in_ok    = int'(in_channel) < CHANNELS;
  assign in_addr  = in_channel[AW-1:0];
  assign in_x     = in_sample_value[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= in_req_type;
      s1_ok_r     <= in_ok;
      s1_addr_r   <= in_addr;
      s1_x_r      <= in_x;
      row_vld_q_r <= row_vld_r[in_addr];
    end
  end

  fwl_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH), .AW(AW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (s1_addr_r),
    .wdata (row_new),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (row_rd)
  );

  fwl_ram #(.WIDTH(SW), .DEPTH(DEPTH), .AW(AW)) u_limit_ram (
    .clk   (clk),
    .we    (hl_we),
    .waddr (s1_addr_r),
    .wdata (s1_x_r),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (hl_rd)
  );

  // Last write wins over a read taken at the same edge
  assign row_cur = (row_fwd_v_r && row_fwd_addr_r == s1_addr_r) ? row_fwd_data_r :
                   (row_vld_q_r ? row_rd : '0);
  assign hl_cur  = (hl_fwd_v_r && hl_fwd_addr_r == s1_addr_r) ? hl_fwd_data_r : hl_rd;

  fwl_eval #(.SW(SW), .ROW_W(ROW_W)) u_eval (
    .kind       (s1_kind_r),
    .in_range   (s1_ok_r),
    .x          (s1_x_r),
    .row        (row_cur),
    .hard_limit (hl_cur),
    .cfg        (cfg_r),
    .row_new    (row_new),
    .row_wr     (row_wr_req),
    .hl_wr      (hl_wr_req),
    .info       (info)
  );

  assign row_we = s1_adv && row_wr_req;
  assign hl_we  = s1_adv && hl_wr_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      row_fwd_v_r <= 1'b0;
      hl_fwd_v_r  <= 1'b0;
    end else begin
      if (row_we) begin
        row_vld_r[s1_addr_r] <= 1'b1;
        row_fwd_v_r          <= 1'b1;
      end
      if (hl_we) begin
        hl_fwd_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_fwd_addr_r <= s1_addr_r;
      row_fwd_data_r <= row_new;
    end
    if (hl_we) begin
      hl_fwd_addr_r <= s1_addr_r;
      hl_fwd_data_r <= s1_x_r;
    end
  end

  fwl_totals u_totals (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (s1_v_r),
    .in_info         (info),
    .ready           (s2_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tripped_now (out_tripped_now),
    .out_alarm       (out_alarm),
    .out_beam_total  (out_beam_total),
    .out_slow_total  (out_slow_total),
    .out_fast_total  (out_fast_total)
  );

  `FWL_ASSERT(a_accept_fills_s1, clk, rst_n, in_acc |=> s1_v_r)
  `FWL_ASSERT(a_s1_holds, clk, rst_n,
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_addr_r) && $stable(s1_kind_r)))
  `FWL_ASSERT(a_one_store_written, clk, rst_n, !(row_we && hl_we))
  `FWL_ASSERT(a_fwd_tracks_write, clk, rst_n,
    row_we |=> (row_fwd_v_r && row_fwd_addr_r == $past(s1_addr_r)))

endmodule
